FILE: rtl/ctfc_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ctfc_pkg
// Types, constants and helpers shared by the clock tree frequency calculator.
// ----------------------------------------------------------------------------
package ctfc_pkg;

  localparam int OSC_W    = 26;
  localparam int FREQ_W   = 32;
  localparam int M_W      = 6;
  localparam int QFIFO_DEPTH = 2;

  localparam logic [1:0] SRC_INT  = 2'd0;
  localparam logic [1:0] SRC_EXT  = 2'd1;
  localparam logic [1:0] SRC_PLLP = 2'd2;
  localparam logic [1:0] SRC_PLLR = 2'd3;

  localparam logic CFG_EXT_OSC = 1'b0;
  localparam logic CFG_INT_OSC = 1'b1;

  localparam logic [OSC_W-1:0] EXT_OSC_RST = 26'd8000000;
  localparam logic [OSC_W-1:0] INT_OSC_RST = 26'd16000000;

  typedef struct packed {
    logic [1:0] source_status;
    logic       pll_from_external;
    logic [5:0] pll_in_divider;
    logic [8:0] pll_multiplier;
    logic [1:0] pll_p_code;
    logic [2:0] pll_r_divider;
    logic [3:0] ahb_presc_code;
    logic [2:0] apb_low_presc_code;
    logic [2:0] apb_high_presc_code;
  } in_item_t;

  typedef struct packed {
    logic [31:0] system_hz;
    logic [31:0] ahb_hz;
    logic [31:0] apb_low_hz;
    logic [31:0] apb_high_hz;
    logic        divide_error;
  } out_item_t;

  // classified job handed from front to back
  typedef struct packed {
    logic             use_pll;
    logic             err;
    logic [OSC_W-1:0] osc;
    logic [5:0]       m;
    logic [8:0]       n;
    logic [3:0]       div;
    logic [3:0]       ahb_sh;
    logic [3:0]       lo_sh;
    logic [3:0]       hi_sh;
  } job_t;

  function automatic logic [3:0] presc_shift(input logic [3:0] code);
    logic [3:0] s;
    unique case (code)
      4'd4:  s = 4'd1;
      4'd5:  s = 4'd2;
      4'd6:  s = 4'd3;
      4'd7:  s = 4'd4;
      4'd8:  s = 4'd1;
      4'd9:  s = 4'd2;
      4'd10: s = 4'd3;
      4'd11: s = 4'd4;
      4'd12: s = 4'd6;
      4'd13: s = 4'd7;
      4'd14: s = 4'd8;
      4'd15: s = 4'd9;
      default: s = 4'd0;
    endcase
    return s;
  endfunction

endpackage
`default_nettype wire

FILE: rtl/ctfc_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ctfc_in_if / ctfc_out_if / ctfc_cfg_if
// Valid/ready channels for items, results and register writes.
// ----------------------------------------------------------------------------
interface ctfc_in_if;
  logic                valid;
  logic                ready;
  ctfc_pkg::in_item_t  data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface ctfc_out_if;
  logic                valid;
  logic                ready;
  ctfc_pkg::out_item_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface ctfc_cfg_if;
  logic        valid;
  logic        ready;
  logic        index;
  logic [25:0] wdata;
  modport source (output valid, output index, output wdata, input ready);
  modport sink   (input valid, input index, input wdata, output ready);
endinterface
`default_nettype wire

FILE: rtl/ctfc_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ctfc_front
// Holds oscillator registers, classifies an item into a job for the back end.
// ----------------------------------------------------------------------------
module ctfc_front (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           cfg_valid,
  input  wire logic           cfg_index,
  input  wire logic [25:0]    cfg_wdata,
  input  ctfc_pkg::in_item_t  item,
  output ctfc_pkg::job_t      job
);
  import ctfc_pkg::*;

  logic [OSC_W-1:0] ext_osc_r, int_osc_r;
  logic [OSC_W-1:0] pll_osc;
  logic [3:0]       div;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ext_osc_r <= EXT_OSC_RST;
      int_osc_r <= INT_OSC_RST;
    end else if (cfg_valid) begin
      if (cfg_index == CFG_EXT_OSC) ext_osc_r <= cfg_wdata;
      else                          int_osc_r <= cfg_wdata;
    end
  end

  always_comb begin
    pll_osc = item.pll_from_external ? ext_osc_r : int_osc_r;
    div     = (item.source_status == SRC_PLLP)
              ? {({1'b0, item.pll_p_code} + 3'd1), 1'b0}
              : {1'b0, item.pll_r_divider};
    job.use_pll = item.source_status[1];
    job.err     = item.source_status[1] && (item.pll_in_divider == '0 || div == '0);
    unique case (item.source_status)
      SRC_INT: job.osc = int_osc_r;
      SRC_EXT: job.osc = ext_osc_r;
      default: job.osc = pll_osc;
    endcase
    job.m      = item.pll_in_divider;
    job.n      = item.pll_multiplier;
    job.div    = div;
    job.ahb_sh = presc_shift(item.ahb_presc_code);
    job.lo_sh  = presc_shift({1'b0, item.apb_low_presc_code});
    job.hi_sh  = presc_shift({1'b0, item.apb_high_presc_code});
  end

endmodule
`default_nettype wire

FILE: rtl/ctfc_queue.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ctfc_queue
// Two-entry job queue between front and back ends.
// ----------------------------------------------------------------------------
module ctfc_queue (
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      push,
  input  ctfc_pkg::job_t push_data,
  output logic           full,
  input  wire logic      pop,
  output logic           not_empty,
  output ctfc_pkg::job_t pop_data
);
  import ctfc_pkg::*;

  job_t       mem_r [QFIFO_DEPTH];
  logic       wp_r, rp_r;
  logic [1:0] cnt_r;

  assign full      = (cnt_r == 2'd2);
  assign not_empty = (cnt_r != 2'd0);
  assign pop_data  = mem_r[rp_r];

  always_ff @(posedge clk) begin
    if (push && !full) mem_r[wp_r] <= push_data;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r <= 1'b0; rp_r <= 1'b0; cnt_r <= 2'd0;
    end else begin
      if (push && !full)     wp_r <= ~wp_r;
      if (pop && not_empty)  rp_r <= ~rp_r;
      cnt_r <= cnt_r + {1'b0, push && !full} - {1'b0, pop && not_empty};
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    full |=> cnt_r <= 2'd2) else $error("queue count overflow");
  a_cnt_track: assert property (@(posedge clk) disable iff (!rst_n)
    (push && !full && !(pop && not_empty)) |=> cnt_r == $past(cnt_r) + 2'd1)
    else $error("queue count lost push");
  a_ptr_eq: assert property (@(posedge clk) disable iff (!rst_n)
    (cnt_r == 2'd0 || cnt_r == 2'd2) |-> wp_r == rp_r)
    else $error("queue pointers out of step");

endmodule
`default_nettype wire

FILE: rtl/ctfc_back.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ctfc_back
// Pipelined PLL math: osc/M radix-2 stages, multiply by N, divide by P/R,
// prescaler shifts. Stalls as a whole on output back-pressure.
// ----------------------------------------------------------------------------
module ctfc_back (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           in_v,
  output logic                in_rdy,
  input  ctfc_pkg::job_t      job,
  output logic                out_v,
  input  wire logic           out_rdy,
  output ctfc_pkg::out_item_t res
);
  import ctfc_pkg::*;

  localparam int NS1 = OSC_W;  // stages of osc / M, one quotient bit each
  localparam int NS2 = FREQ_W; // stages of vco / div
  localparam int NST = NS1 + 1 + NS2 + 1;

  logic adv;
  logic [NST-1:0] v_r;
  assign adv    = !out_v || out_rdy;
  assign in_rdy = adv;
  assign out_v  = v_r[NST-1];

  always_ff @(posedge clk) begin
    if (!rst_n) v_r <= '0;
    else if (adv) v_r <= {v_r[NST-2:0], in_v};
  end

  // stage group 1: osc / m
  job_t              j1_r [1:NS1];
  logic [OSC_W-1:0]  q1_r [1:NS1];
  logic [M_W-1:0]    r1_r [1:NS1];
  for (genvar s = 0; s < NS1; s++) begin : g_d1
    job_t             jc;
    logic [OSC_W-1:0] qc;
    logic [M_W-1:0]   rc;
    logic [M_W:0]     t;
    logic [M_W:0]     d;
    if (s == 0) begin : g_src
      assign jc = job;
      assign qc = job.osc;
      assign rc = '0;
    end else begin : g_src
      assign jc = j1_r[s];
      assign qc = q1_r[s];
      assign rc = r1_r[s];
    end
    always_comb begin
      t = {rc, qc[OSC_W-1]};
      d = t - {1'b0, jc.m};
    end
    always_ff @(posedge clk) begin
      if (adv) begin
        j1_r[s+1] <= jc;
        if (!d[M_W]) begin
          r1_r[s+1] <= d[M_W-1:0];
          q1_r[s+1] <= {qc[OSC_W-2:0], 1'b1};
        end else begin
          r1_r[s+1] <= t[M_W-1:0];
          q1_r[s+1] <= {qc[OSC_W-2:0], 1'b0};
        end
      end
    end
  end

  // multiply
  job_t         jm_r;
  logic [31:0]  vco_r;
  always_ff @(posedge clk) begin
    if (adv) begin
      jm_r  <= j1_r[NS1];
      vco_r <= 32'({6'd0, q1_r[NS1]} * {23'd0, j1_r[NS1].n});
    end
  end

  // stage group 2: vco / div
  job_t         j2_r [1:NS2];
  logic [31:0]  q2_r [1:NS2];
  logic [2:0]   r2_r [1:NS2];
  for (genvar s = 0; s < NS2; s++) begin : g_d2
    job_t        jc;
    logic [31:0] qc;
    logic [2:0]  rc;
    logic [3:0]  t, d;
    if (s == 0) begin : g_src
      assign jc = jm_r;
      assign qc = jm_r.use_pll ? vco_r : {6'd0, jm_r.osc};
      assign rc = '0;
    end else begin : g_src
      assign jc = j2_r[s];
      assign qc = q2_r[s];
      assign rc = r2_r[s];
    end
    always_comb begin
      t = {rc, qc[31]};
      d = t - jc.div;
    end
    always_ff @(posedge clk) begin
      if (adv) begin
        j2_r[s+1] <= jc;
        if (!d[3] && jc.use_pll) begin
          r2_r[s+1] <= d[2:0];
          q2_r[s+1] <= {qc[30:0], 1'b1};
        end else if (jc.use_pll) begin
          r2_r[s+1] <= t[2:0];
          q2_r[s+1] <= {qc[30:0], 1'b0};
        end else begin
          r2_r[s+1] <= '0;
          q2_r[s+1] <= {qc[30:0], qc[31]};
        end
      end
    end
  end

  // output stage
  logic [31:0] sys, ahb;
  always_comb begin
    sys = j2_r[NS2].err ? 32'd0 : q2_r[NS2];
    ahb = sys >> j2_r[NS2].ahb_sh;
  end
  always_ff @(posedge clk) begin
    if (adv) begin
      res.system_hz    <= sys;
      res.ahb_hz       <= ahb;
      res.apb_low_hz   <= ahb >> j2_r[NS2].lo_sh;
      res.apb_high_hz  <= ahb >> j2_r[NS2].hi_sh;
      res.divide_error <= j2_r[NS2].err;
    end
  end

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_v && !out_rdy) |=> out_v) else $error("result dropped");
  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_v && res.divide_error) |-> res.system_hz == 32'd0)
    else $error("error result nonzero");
  a_adv: assert property (@(posedge clk) disable iff (!rst_n)
    !adv |=> $stable(v_r)) else $error("pipe moved while stalled");

endmodule
`default_nettype wire

FILE: rtl/clock_tree_frequency_calc_core.sv
`default_nettype none
// From input transfer to result valid an item passes the queue entry, then
// 26 osc/M divider stages, multiplier stage, 32 vco/div stages, output register.
// Throughput: one item per cycle; the pipeline stalls only on result back-pressure.
// Reset: synchronous active-low rst_n; oscillators return to 8 MHz / 16 MHz.
// ----------------------------------------------------------------------------
// clock_tree_frequency_calc_core
// System, AHB and APB frequency calculator, front/queue/back structure.
// ----------------------------------------------------------------------------
module clock_tree_frequency_calc_core (
  input  wire logic   clk,
  input  wire logic   rst_n,
  ctfc_in_if.sink     in_ch,
  ctfc_out_if.source  out_ch,
  ctfc_cfg_if.sink    cfg_ch
);
  import ctfc_pkg::*;

  job_t fjob, qjob;
  logic full, ne, brdy;

  assign cfg_ch.ready = 1'b1;
  assign in_ch.ready  = !full;

  ctfc_front u_front (
    .clk, .rst_n,
    .cfg_valid (cfg_ch.valid),
    .cfg_index (cfg_ch.index),
    .cfg_wdata (cfg_ch.wdata),
    .item      (in_ch.data),
    .job       (fjob)
  );

  ctfc_queue u_queue (
    .clk, .rst_n,
    .push      (in_ch.valid),
    .push_data (fjob),
    .full      (full),
    .pop       (brdy),
    .not_empty (ne),
    .pop_data  (qjob)
  );

  ctfc_back u_back (
    .clk, .rst_n,
    .in_v    (ne),
    .in_rdy  (brdy),
    .job     (qjob),
    .out_v   (out_ch.valid),
    .out_rdy (out_ch.ready),
    .res     (out_ch.data)
  );

endmodule
`default_nettype wire
